// ----- rtl/core/spcs_pkg.sv -----
package spcs_pkg;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_CELLS_X       = 3'd0,
        REG_CELLS_Y       = 3'd1,
        REG_CELLS_Z       = 3'd2,
        REG_INV_SPACING_X = 3'd3,
        REG_INV_SPACING_Y = 3'd4,
        REG_INV_SPACING_Z = 3'd5,
        REG_GRID_KIND     = 3'd6
    } reg_idx_t;

    localparam int CELLS_W = 9;
    localparam int INV_W   = 24;
    localparam int IDX_W   = 8;
    localparam int COEF_W  = 32;

    localparam logic [CELLS_W-1:0] CELLS_RST = 9'd64;
    localparam logic [INV_W-1:0]   INV_RST   = 24'd65536;
    localparam logic               GRID_RST  = 1'b1;
    localparam logic               GRID_NODE = 1'b0;

    // quarter-turn angle, Q0.30
    localparam int ANG_W   = 30;
    localparam int ANG_BPS = 5;
    localparam int FRAC    = 30;

    // odd sine polynomial, Q30
    localparam int T_W = 31;
    localparam logic [T_W-1:0] SIN_C1 = 31'd1686629713;
    localparam logic [T_W-1:0] SIN_C3 = 31'd693598668;
    localparam logic [T_W-1:0] SIN_C5 = 31'd85569306;
    localparam logic [T_W-1:0] SIN_C7 = 31'd5026995;
    localparam logic [T_W-1:0] SIN_C9 = 31'd172272;

    localparam int S_W    = 31;
    localparam int D_W    = 26;
    localparam int TERM_W = 2 * D_W;
    localparam int DEN_W  = TERM_W + 2;

    // divider stages plus eight arithmetic stages
    localparam int AXIS_LAT = ANG_W / ANG_BPS + 8;

    localparam int Q_W   = 32;
    localparam int Q_BPS = 1;
    localparam int Q_LAT = Q_W / Q_BPS;

    typedef struct packed {
        logic [COEF_W-1:0] mag;
        logic              neg;
        logic              err;
        logic              zres;
    } front_t;

    typedef struct packed {
        logic neg;
        logic err;
        logic zres;
        logic ovf;
    } back_t;

endpackage

// ----- rtl/core/spectral_poisson_coef_solve.sv -----
// Spectral Poisson coefficient solver. Each beat carries one transform-domain
// Laplacian coefficient (signed Q16.16) and its x/y/z frequency indices; the
// result beat carries coef / -(dx^2+dy^2+dz^2), saturated to 32 bits, where
// d = 2*sin(idx*pi/(2*cells))*inv_spacing per axis. Indices outside the mode
// range (node grid 1..cells-1, cell grid 0..cells-1) give index_error with a
// zero result; the cell-grid all-zero mode gives zero. The pipeline takes one
// beat per clock while the output is not held by a stall. Its stages are the
// angle divider, sine and square, the sum, the one-bit-per-stage quotient
// divider and the output register. A stall on the output freezes the whole
// pipeline. Registers are to be written only while idle.
module spectral_poisson_coef_solve #(
    parameter int MAX_CELLS = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  freq_x,
    input  logic [7:0]  freq_y,
    input  logic [7:0]  freq_z,
    input  logic signed [31:0] laplacian_coef,

    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] potential_coef,
    output logic        index_error
);

    localparam int NW  = $clog2(MAX_CELLS + 1);
    localparam int AL  = spcs_pkg::AXIS_LAT;
    localparam int QL  = spcs_pkg::Q_LAT;
    localparam int DNW = spcs_pkg::DEN_W;

    // configuration registers
    logic [spcs_pkg::CELLS_W-1:0] cells_x_reg, cells_y_reg, cells_z_reg;
    logic [spcs_pkg::INV_W-1:0]   inv_x_reg, inv_y_reg, inv_z_reg;
    logic                         grid_kind_reg;
    spcs_pkg::reg_idx_t           ridx;

    assign ridx   = spcs_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg   <= spcs_pkg::CELLS_RST;
            cells_y_reg   <= spcs_pkg::CELLS_RST;
            cells_z_reg   <= spcs_pkg::CELLS_RST;
            inv_x_reg     <= spcs_pkg::INV_RST;
            inv_y_reg     <= spcs_pkg::INV_RST;
            inv_z_reg     <= spcs_pkg::INV_RST;
            grid_kind_reg <= spcs_pkg::GRID_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                spcs_pkg::REG_CELLS_X:       cells_x_reg   <= pwdata[8:0];
                spcs_pkg::REG_CELLS_Y:       cells_y_reg   <= pwdata[8:0];
                spcs_pkg::REG_CELLS_Z:       cells_z_reg   <= pwdata[8:0];
                spcs_pkg::REG_INV_SPACING_X: inv_x_reg     <= pwdata[23:0];
                spcs_pkg::REG_INV_SPACING_Y: inv_y_reg     <= pwdata[23:0];
                spcs_pkg::REG_INV_SPACING_Z: inv_z_reg     <= pwdata[23:0];
                spcs_pkg::REG_GRID_KIND:     grid_kind_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            spcs_pkg::REG_CELLS_X:       prdata = {23'd0, cells_x_reg};
            spcs_pkg::REG_CELLS_Y:       prdata = {23'd0, cells_y_reg};
            spcs_pkg::REG_CELLS_Z:       prdata = {23'd0, cells_z_reg};
            spcs_pkg::REG_INV_SPACING_X: prdata = {8'd0, inv_x_reg};
            spcs_pkg::REG_INV_SPACING_Y: prdata = {8'd0, inv_y_reg};
            spcs_pkg::REG_INV_SPACING_Z: prdata = {8'd0, inv_z_reg};
            spcs_pkg::REG_GRID_KIND:     prdata = {31'd0, grid_kind_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // pipeline advance
    logic out_valid_reg;
    logic adv;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    function automatic logic [NW-1:0] eff_cells(input logic [spcs_pkg::CELLS_W-1:0] c);
        return (32'(c) > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(c);
    endfunction

    function automatic logic idx_ok(input logic [7:0] i, input logic [NW-1:0] n,
                                    input logic g);
        return (32'(i) < 32'(n)) && !(g == spcs_pkg::GRID_NODE && i == 8'd0);
    endfunction

    logic [NW-1:0] nx, ny, nz;
    assign nx = eff_cells(cells_x_reg);
    assign ny = eff_cells(cells_y_reg);
    assign nz = eff_cells(cells_z_reg);

    spcs_pkg::front_t front_in;
    logic             coef_neg;
    logic [31:0]      coef_mag;

    assign coef_neg = laplacian_coef[31];
    assign coef_mag = coef_neg ? (~laplacian_coef + 32'd1) : laplacian_coef;

    always_comb
    begin
        front_in.mag  = coef_mag;
        front_in.neg  = coef_neg;
        front_in.err  = !idx_ok(freq_x, nx, grid_kind_reg)
                     || !idx_ok(freq_y, ny, grid_kind_reg)
                     || !idx_ok(freq_z, nz, grid_kind_reg);
        front_in.zres = (freq_x == 8'd0 && freq_y == 8'd0 && freq_z == 8'd0)
                     || coef_mag == 32'd0;
    end

    // axis terms
    logic [spcs_pkg::TERM_W-1:0] term_x, term_y, term_z;

    spcs_axis_term #(.NW(NW)) u_ax_x (
        .clk (clk), .en (adv), .idx (freq_x), .cells_eff (nx),
        .inv_spacing (inv_x_reg), .term (term_x)
    );
    spcs_axis_term #(.NW(NW)) u_ax_y (
        .clk (clk), .en (adv), .idx (freq_y), .cells_eff (ny),
        .inv_spacing (inv_y_reg), .term (term_y)
    );
    spcs_axis_term #(.NW(NW)) u_ax_z (
        .clk (clk), .en (adv), .idx (freq_z), .cells_eff (nz),
        .inv_spacing (inv_z_reg), .term (term_z)
    );

    // side line alongside the axis units
    spcs_pkg::front_t front_reg [AL];
    logic [AL-1:0]    fvld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fvld_reg <= '0;
        else if (adv)
            fvld_reg <= {fvld_reg[AL-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg[0] <= front_in;
            for (int k = 1; k < AL; k++)
                front_reg[k] <= front_reg[k-1];
        end
    end

    // denominator sum
    logic [DNW-1:0]   den_reg;
    spcs_pkg::front_t sum_reg;
    logic             sum_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_vld_reg <= 1'b0;
        else if (adv)
            sum_vld_reg <= fvld_reg[AL-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg <= DNW'(term_x) + DNW'(term_y) + DNW'(term_z);
            sum_reg <= front_reg[AL-1];
        end
    end

    // quotient of mag*2^32 / den; mag >= den means it reaches 2^32
    logic [spcs_pkg::Q_W-1:0] quot;
    spcs_pkg::back_t          back_in;

    always_comb
    begin
        back_in.neg  = sum_reg.neg;
        back_in.err  = sum_reg.err;
        back_in.zres = sum_reg.zres;
        back_in.ovf  = DNW'(sum_reg.mag) >= den_reg;
    end

    spcs_div_pipe #(
        .DW  (DNW),
        .QW  (spcs_pkg::Q_W),
        .BPS (spcs_pkg::Q_BPS)
    ) u_q_div (
        .clk    (clk),
        .en     (adv),
        .rem_in (DNW'(sum_reg.mag)),
        .den_in (den_reg),
        .quot   (quot)
    );

    spcs_pkg::back_t back_reg [QL];
    logic [QL-1:0]   bvld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bvld_reg <= '0;
        else if (adv)
            bvld_reg <= {bvld_reg[QL-2:0], sum_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            back_reg[0] <= back_in;
            for (int k = 1; k < QL; k++)
                back_reg[k] <= back_reg[k-1];
        end
    end

    // output formatting
    spcs_pkg::back_t b_end;
    logic [31:0]     res_next;
    logic [31:0]     res_reg;
    logic            err_reg;
    logic            big;

    assign b_end = back_reg[QL-1];
    assign big   = b_end.ovf || quot[31];

    always_comb
    begin
        if (b_end.err || b_end.zres)
            res_next = 32'd0;
        else if (b_end.neg)
            res_next = big ? 32'h7FFF_FFFF : quot;
        else
            res_next = big ? 32'h8000_0000 : (32'd0 - quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= bvld_reg[QL-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
            err_reg <= b_end.err;
        end
    end

    assign out_valid      = out_valid_reg;
    assign potential_coef = res_reg;
    assign index_error    = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> res_reg == 32'd0)
        else $error("index error beat with nonzero result");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> in_stall)
        else $error("input taken while output is stalled");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result dropped");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(bvld_reg) && $stable(fvld_reg))
        else $error("pipeline moved during stall");

endmodule

// ----- rtl/core/spcs_div_pipe.sv -----
module spcs_div_pipe #(
    parameter int DW  = 9,
    parameter int QW  = 30,
    parameter int BPS = 5
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quot
);

    localparam int NS = QW / BPS;

    logic [DW-1:0] rem_reg  [NS];
    logic [DW-1:0] den_reg  [NS];
    logic [QW-1:0] quot_reg [NS];

    logic [DW-1:0] rem_src  [NS];
    logic [DW-1:0] den_src  [NS];
    logic [QW-1:0] quot_src [NS];

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [DW:0]    r;
        logic [DW-1:0]  rs;
        logic [BPS-1:0] b;

        if (k == 0) begin : g_first
            assign rem_src[k]  = rem_in;
            assign den_src[k]  = den_in;
            assign quot_src[k] = '0;
        end else begin : g_next
            assign rem_src[k]  = rem_reg[k-1];
            assign den_src[k]  = den_reg[k-1];
            assign quot_src[k] = quot_reg[k-1];
        end

        // restoring steps, remainder stays below the divisor if the input remainder is below it
        always_comb
        begin
            r  = '0;
            b  = '0;
            rs = rem_src[k];
            for (int j = 0; j < BPS; j++)
            begin
                r = {rs, 1'b0};
                if (r >= {1'b0, den_src[k]})
                begin
                    r = r - {1'b0, den_src[k]};
                    b[BPS-1-j] = 1'b1;
                end
                rs = r[DW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rs;
                den_reg[k]  <= den_src[k];
                quot_reg[k] <= {quot_src[k][QW-BPS-1:0], b};
            end
        end
    end

    assign quot = quot_reg[NS-1];

endmodule

// ----- rtl/core/spcs_axis_term.sv -----
module spcs_axis_term #(
    parameter int NW = 9
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [spcs_pkg::IDX_W-1:0]       idx,
    input  logic [NW-1:0]                    cells_eff,
    input  logic [spcs_pkg::INV_W-1:0]       inv_spacing,
    output logic [spcs_pkg::TERM_W-1:0]      term
);

    localparam int AW = spcs_pkg::ANG_W;
    localparam int TW = spcs_pkg::T_W;

    function automatic logic [TW-1:0] horner(input logic [AW-1:0] a2,
                                             input logic [TW-1:0] t,
                                             input logic [TW-1:0] c);
        logic [AW+TW-1:0] p;
        p = {{TW{1'b0}}, a2} * {{AW{1'b0}}, t};
        return c - TW'(p >> spcs_pkg::FRAC);
    endfunction

    logic [AW-1:0] ang;

    spcs_div_pipe #(
        .DW  (NW),
        .QW  (AW),
        .BPS (spcs_pkg::ANG_BPS)
    ) u_ang_div (
        .clk    (clk),
        .en     (en),
        .rem_in (NW'(idx)),
        .den_in (cells_eff),
        .quot   (ang)
    );

    logic [AW-1:0]     a1_reg, a2_reg, a3_reg, a4_reg, a5_reg;
    logic [AW-1:0]     sq1_reg, sq2_reg, sq3_reg, sq4_reg;
    logic [TW-1:0]     t7_reg, t5_reg, t3_reg, t1_reg;
    logic [spcs_pkg::S_W-1:0]    s_reg;
    logic [spcs_pkg::D_W-1:0]    d_reg;
    logic [spcs_pkg::TERM_W-1:0] term_reg;

    logic [2*AW-1:0]   sq_next;
    logic [AW+TW-1:0]  s_next;
    logic [spcs_pkg::S_W+spcs_pkg::INV_W-1:0] d_next;

    assign sq_next = {{AW{1'b0}}, ang} * {{AW{1'b0}}, ang};
    assign s_next  = {{TW{1'b0}}, a5_reg} * {{AW{1'b0}}, t1_reg};
    assign d_next  = {{spcs_pkg::INV_W{1'b0}}, s_reg}
                   * {{spcs_pkg::S_W{1'b0}}, inv_spacing};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= ang;
            sq1_reg  <= sq_next[2*AW-1:spcs_pkg::FRAC];
            a2_reg   <= a1_reg;
            sq2_reg  <= sq1_reg;
            t7_reg   <= horner(sq1_reg, spcs_pkg::SIN_C9, spcs_pkg::SIN_C7);
            a3_reg   <= a2_reg;
            sq3_reg  <= sq2_reg;
            t5_reg   <= horner(sq2_reg, t7_reg, spcs_pkg::SIN_C5);
            a4_reg   <= a3_reg;
            sq4_reg  <= sq3_reg;
            t3_reg   <= horner(sq3_reg, t5_reg, spcs_pkg::SIN_C3);
            a5_reg   <= a4_reg;
            t1_reg   <= horner(sq4_reg, t3_reg, spcs_pkg::SIN_C1);
            s_reg    <= s_next[spcs_pkg::FRAC+spcs_pkg::S_W-1:spcs_pkg::FRAC];
            // 2*s*inv >> 30
            d_reg    <= d_next[29+spcs_pkg::D_W-1:29];
            term_reg <= {{spcs_pkg::D_W{1'b0}}, d_reg} * {{spcs_pkg::D_W{1'b0}}, d_reg};
        end
    end

    assign term = term_reg;

endmodule

// ----- verif/tb_spectral_poisson_coef_solve.sv -----
`timescale 1ns / 100ps

typedef struct {
    logic signed [31:0] coef;
    logic               err;
} potential_t;

class potential_board;
    potential_t pending[$];
    int unsigned errors;
    int unsigned checked;

    logic [8:0]  cells[3];
    logic [23:0] inv[3];
    logic        grid;

    function new();
        errors = 0;
        checked = 0;
        for (int i = 0; i < 3; i++) begin
            cells[i] = spcs_pkg::CELLS_RST;
            inv[i] = spcs_pkg::INV_RST;
        end
        grid = spcs_pkg::GRID_RST;
    endfunction

    function void set_reg(spcs_pkg::reg_idx_t idx, logic [31:0] val);
        case (idx)
            spcs_pkg::REG_CELLS_X:       cells[0] = val[8:0];
            spcs_pkg::REG_CELLS_Y:       cells[1] = val[8:0];
            spcs_pkg::REG_CELLS_Z:       cells[2] = val[8:0];
            spcs_pkg::REG_INV_SPACING_X: inv[0] = val[23:0];
            spcs_pkg::REG_INV_SPACING_Y: inv[1] = val[23:0];
            spcs_pkg::REG_INV_SPACING_Z: inv[2] = val[23:0];
            spcs_pkg::REG_GRID_KIND:     grid = val[0];
            default: ;
        endcase
    endfunction

    function logic [63:0] sine_q30(logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] t;
        a2 = (a * a) >> 30;
        t = 64'(spcs_pkg::SIN_C9);
        t = 64'(spcs_pkg::SIN_C7) - ((a2 * t) >> 30);
        t = 64'(spcs_pkg::SIN_C5) - ((a2 * t) >> 30);
        t = 64'(spcs_pkg::SIN_C3) - ((a2 * t) >> 30);
        t = 64'(spcs_pkg::SIN_C1) - ((a2 * t) >> 30);
        return (a * t) >> 30;
    endfunction

    function logic [63:0] mult_sq(int unsigned f, int unsigned n, logic [23:0] iv);
        logic [63:0] a;
        logic [63:0] d;
        a = (64'(f) << 30) / 64'(n);
        d = (2 * sine_q30(a) * 64'(iv)) >> 30;
        return d * d;
    endfunction

    function void note_input(logic [7:0] f[3], logic signed [31:0] c);
        potential_t p;
        int unsigned n[3];
        logic ok;
        logic neg;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] q;
        ok = 1;
        for (int i = 0; i < 3; i++) begin
            n[i] = (cells[i] > 256) ? 256 : cells[i];
            if (f[i] >= n[i] || (grid == spcs_pkg::GRID_NODE && f[i] == 0))
                ok = 0;
        end
        neg = c[31];
        mag = neg ? 64'(-c) : 64'(c);
        if (neg && mag[31:0] == 0) mag = 64'h8000_0000;
        mag = {32'b0, mag[31:0]};
        p.err = !ok;
        p.coef = 0;
        if (ok && !(f[0] == 0 && f[1] == 0 && f[2] == 0) && mag != 0) begin
            den = 0;
            for (int i = 0; i < 3; i++)
                den += mult_sq(f[i], n[i], inv[i]);
            q = (den == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (mag << 32) / den;
            if (neg)
                p.coef = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            else
                p.coef = (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        end
        pending.insert(pending.size(), p);
    endfunction

    task check_result(logic signed [31:0] c, logic e);
        potential_t p;
        checked++;
        if (pending.size() == 0) begin
            report("unexpected beat", 0, c);
            return;
        end
        p = pending.pop_front();
        if (e !== p.err) report("index_error", p.err, e);
        if (c !== p.coef) report("potential_coef", p.coef, c);
    endtask

    task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        errors++;
        $display("ERR %0t %s exp %h got %h", $realtime, what, exp_v, got_v);
    endtask
endclass

module tb_spectral_poisson_coef_solve;
    localparam int LAT = 48;
    localparam int WATCHDOG = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  freq_x = 0, freq_y = 0, freq_z = 0;
    logic signed [31:0] laplacian_coef = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic signed [31:0] potential_coef;
    logic        index_error;

    potential_board board = new();
    int unsigned idle_cycles = 0;
    int unsigned sent = 0;
    bit hold_off = 0;
    bit sink_busy = 1;

    always #1 clk = ~clk;

    spectral_poisson_coef_solve dut (.*);

    always @(posedge clk) begin
        if (in_valid && !in_stall)
            board.note_input('{freq_x, freq_y, freq_z}, laplacian_coef);
        if (out_valid && !out_stall)
            board.check_result(potential_coef, index_error);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !sink_busy)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function int unsigned gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned g;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (200) @(negedge clk);
                hold_off = 0;
                out_stall <= 0;
            end else if ($urandom_range(0, 2) == 0) begin
                g = gap_len() + 1;
                out_stall <= 1;
                repeat (g) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic reg_write(spcs_pkg::reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, val);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send(logic [7:0] fx, logic [7:0] fy, logic [7:0] fz,
                        logic signed [31:0] c, bit gaps);
        int unsigned g;
        g = gaps ? (($urandom_range(0, 3) == 0) ? gap_len() : 0) : 0;
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1;
        freq_x <= fx; freq_y <= fy; freq_z <= fz; laplacian_coef <= c;
        do @(posedge clk); while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
        @(negedge clk);
    endtask

    // mostly in-range indices, some beyond the count
    function logic [7:0] pick_freq(int unsigned n);
        int unsigned lim;
        lim = (n > 256) ? 256 : n;
        if ($urandom_range(0, 9) == 0 || lim == 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return (lim > 0) ? 8'(lim - 1) : 8'd0;
            default: return 8'($urandom_range(0, lim - 1));
        endcase
    endfunction

    function logic signed [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            3: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int unsigned count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && count > 100) hold_off = 1;
            send(pick_freq(board.cells[0]), pick_freq(board.cells[1]),
                 pick_freq(board.cells[2]), pick_coef(), 1);
        end
        drain();
    endtask

    task automatic config_all(logic [8:0] cx, logic [8:0] cy, logic [8:0] cz,
                              logic [23:0] ix, logic [23:0] iy, logic [23:0] iz,
                              logic g);
        reg_write(spcs_pkg::REG_CELLS_X, 32'(cx));
        reg_write(spcs_pkg::REG_CELLS_Y, 32'(cy));
        reg_write(spcs_pkg::REG_CELLS_Z, 32'(cz));
        reg_write(spcs_pkg::REG_INV_SPACING_X, 32'(ix));
        reg_write(spcs_pkg::REG_INV_SPACING_Y, 32'(iy));
        reg_write(spcs_pkg::REG_INV_SPACING_Z, 32'(iz));
        reg_write(spcs_pkg::REG_GRID_KIND, 32'(g));
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        sink_busy = 1;

        // directed beats at reset settings (cell grid, 64 cells)
        send(0, 0, 0, 32'sh0001_0000, 0);
        send(0, 0, 0, 0, 0);
        send(1, 0, 0, 32'sh0001_0000, 0);
        send(63, 63, 63, 32'sh7FFF_FFFF, 0);
        send(63, 63, 63, 32'sh8000_0000, 0);
        send(64, 1, 1, 32'sh0001_0000, 0);
        send(255, 255, 255, -32'sh1, 0);
        send(1, 1, 1, 32'sh7FFF_FFFF, 0);
        send(1, 1, 1, 32'sh8000_0000, 0);
        send(1, 0, 0, 0, 0);
        send(0, 32, 0, -32'sh0001_0000, 0);
        send(170, 85, 2, 32'sh5555_AAAA, 0);
        drain();

        // node grid, large counts clipped to 256
        config_all(9'd511, 9'd256, 9'd2, 24'hFFFFFF, 24'd1, 24'd65536, 0);
        send(0, 1, 1, 32'sh0001_0000, 0);
        send(1, 1, 1, 32'sh0001_0000, 0);
        send(255, 255, 1, 32'sh8000_0000, 0);
        send(255, 128, 1, 32'sh7FFF_FFFF, 0);
        send(1, 1, 2, 32'sh0001_0000, 0);
        drain();

        // tiny spacing: zero denominator, saturation
        config_all(9'd8, 9'd8, 9'd8, 24'd1, 24'd1, 24'd1, 1);
        send(1, 1, 1, 32'sh0001_0000, 0);
        send(1, 1, 1, -32'sh0001_0000, 0);
        send(1, 1, 1, 0, 0);
        drain();

        // cells below minimum make all indices invalid
        config_all(9'd1, 9'd0, 9'd4, 24'd65536, 24'd65536, 24'd65536, 0);
        send(0, 0, 0, 32'sh1234, 0);
        send(1, 1, 1, 32'sh1234, 0);
        drain();

        config_all(9'd64, 9'd64, 9'd64, 24'd65536, 24'd65536, 24'd65536, 1);
        random_phase(500);
        config_all(9'd256, 9'd256, 9'd256, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
        random_phase(400);
        for (int p = 0; p < 3; p++) begin
            config_all(9'($urandom_range(2, 300)), 9'($urandom_range(2, 300)),
                       9'($urandom_range(2, 300)), 24'($urandom_range(1, 24'hFFFFFF)),
                       24'($urandom_range(1, 24'h3FFFF)),
                       24'($urandom_range(1, 24'hFFFFFF)),
                       1'($urandom_range(0, 1)));
            random_phase(300);
        end
        // masking of the upper register bits
        reg_write(spcs_pkg::REG_CELLS_X, 32'hFFFF_FE10);
        reg_write(spcs_pkg::REG_INV_SPACING_Y, 32'hFF01_0000);
        random_phase(40);

        sink_busy = 0;
        $display("covered %0d beats, %0d results over node/cell grids,", sent, board.checked);
        $display("clipped and undersized cell counts, and spacing extremes");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
